### rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_SET = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CMP  = 2'd1,
        ST_UPD  = 2'd2
    } state_t;

    typedef struct packed {
        logic load;
        logic compare;
        logic update;
    } dp_cmd_t;

    typedef struct packed {
        logic is_get;
    } dp_stat_t;

endpackage

### rtl/lkvc_ctrl.sv
// Controller state machine for the LRU key/value cache.
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_finish;

    // Hold the update while a get result would overwrite an untaken one
    assign can_finish = !(stat.is_get && out_valid_reg && !m_ready);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (can_finish) state_next = s_valid ? ST_CMP : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready     = 1'b0;
        cmd.compare = 1'b0;
        cmd.update  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_CMP: begin
                cmd.compare = 1'b1;
            end
            ST_UPD: begin
                s_ready    = can_finish;
                cmd.update = can_finish;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.load = s_valid && s_ready;
    end

    // Track the result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.update && stat.is_get) out_valid_next = 1'b1;
        else if (m_ready)              out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

### rtl/lkvc_dp.sv
// Datapath for the LRU key/value cache: entry cells, recency ranks and result register.
module lkvc_dp
    import lkvc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [CAP_W-1:0] cfg_data,
    input  in_item_t         s_item,
    output out_item_t        m_item,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat
);

    logic [CAP_W-1:0] cap_reg;
    in_item_t         item_reg;
    out_item_t        out_reg;

    logic [KEY_W-1:0] key_reg  [ENTRIES];
    logic [VAL_W-1:0] val_reg  [ENTRIES];
    logic [IDX_W-1:0] rank_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]   fill_reg;

    logic [KEY_W-1:0] key_next  [ENTRIES];
    logic [VAL_W-1:0] val_next  [ENTRIES];
    logic [IDX_W-1:0] rank_next [ENTRIES];
    logic [ENTRIES-1:0] valid_next;
    logic [CNT_W-1:0]   fill_next;

    logic [ENTRIES-1:0] match_reg;
    logic               hit_reg;

    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               need_evict;
    logic [CNT_W-1:0]   fill_dec;
    logic [IDX_W-1:0]   oldest_rank;
    logic [ENTRIES-1:0] victim_vec;
    logic [ENTRIES-1:0] valid_after;
    logic [ENTRIES-1:0] free_vec;
    logic [IDX_W-1:0]   hit_rank;
    logic [VAL_W-1:0]   hit_val;

    // Compare a key against every cell
    function automatic logic [ENTRIES-1:0] compare_vec(input logic [KEY_W-1:0] k);
        logic [ENTRIES-1:0] v;
        for (int i = 0; i < ENTRIES; i++) v[i] = (key_reg[i] == k);
        return v;
    endfunction

    // Clamp the capacity to 1 .. ENTRIES
    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_reg == '0)                    eff_cap = CMP_W'(1);
        else if (cap_ext > CMP_W'(ENTRIES))   eff_cap = CMP_W'(ENTRIES);
        else                                  eff_cap = cap_ext;
        need_evict = CMP_W'(fill_reg) >= eff_cap;
    end

    // Pick the oldest entry and the lowest free slot once it is gone
    always_comb begin
        fill_dec    = fill_reg - CNT_W'(1);
        oldest_rank = fill_dec[IDX_W-1:0];
        for (int i = 0; i < ENTRIES; i++) begin
            victim_vec[i] = need_evict && valid_reg[i] && (rank_reg[i] == oldest_rank);
        end
        valid_after = valid_reg & ~victim_vec;
        free_vec    = ~valid_after & (valid_after + ENTRIES'(1));
    end

    // Read rank and value of the matching cell
    always_comb begin
        hit_rank = '0;
        hit_val  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match_reg[i]) begin
                hit_rank = hit_rank | rank_reg[i];
                hit_val  = hit_val  | val_reg[i];
            end
        end
    end

    // Work out the next contents of every cell
    always_comb begin
        valid_next = valid_reg;
        fill_next  = fill_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            key_next[i]  = key_reg[i];
            val_next[i]  = val_reg[i];
            rank_next[i] = rank_reg[i];
        end
        if (cmd.update) begin
            if (hit_reg) begin
                // promote the matching entry, younger ones age by one
                for (int i = 0; i < ENTRIES; i++) begin
                    if (match_reg[i]) begin
                        rank_next[i] = '0;
                        if (item_reg.cmd == CMD_SET) val_next[i] = item_reg.value;
                    end else if (valid_reg[i] && (rank_reg[i] < hit_rank)) begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
            end else if (item_reg.cmd == CMD_SET) begin
                // drop the oldest if full, age the rest, insert as most recent
                for (int i = 0; i < ENTRIES; i++) begin
                    if (free_vec[i]) begin
                        key_next[i]   = item_reg.key;
                        val_next[i]   = item_reg.value;
                        rank_next[i]  = '0;
                        valid_next[i] = 1'b1;
                    end else if (valid_after[i]) begin
                        rank_next[i]  = rank_reg[i] + IDX_W'(1);
                    end else begin
                        rank_next[i]  = '0;
                        valid_next[i] = 1'b0;
                    end
                end
                fill_next = fill_reg - CNT_W'(need_evict) + CNT_W'(1);
            end
        end
    end

    // Control state of the cells
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CAP_RESET;
            valid_reg <= '0;
            fill_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++) rank_reg[i] <= '0;
        end else begin
            if (cfg_valid) cap_reg <= cfg_data;
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
            for (int i = 0; i < ENTRIES; i++) rank_reg[i] <= rank_next[i];
        end
    end

    // Payload: item, compare result, stores and result
    always_ff @(posedge aclk) begin
        if (cmd.load) item_reg <= s_item;
        if (cmd.compare) begin
            for (int i = 0; i < ENTRIES; i++) begin
                match_reg[i] <= valid_reg[i] && (key_reg[i] == item_reg.key);
            end
            hit_reg <= |(valid_reg & compare_vec(item_reg.key));
        end
        for (int i = 0; i < ENTRIES; i++) begin
            key_reg[i] <= key_next[i];
            val_reg[i] <= val_next[i];
        end
        if (cmd.update && (item_reg.cmd == CMD_GET)) begin
            out_reg.hit        <= hit_reg;
            out_reg.read_value <= hit_reg ? hit_val : '0;
        end
    end

    assign stat.is_get = (item_reg.cmd == CMD_GET);
    assign m_item      = out_reg;

endmodule

### rtl/lru_key_value_cache_unit.sv
// Top level of the LRU key/value cache: controller and datapath.
//
//   channel | ports                       | moves
//   --------+-----------------------------+---------------------------------
//   input   | s_valid s_ready s_item      | one get or set item
//   result  | m_valid m_ready m_item      | hit flag and value, one per get
//   config  | cfg_valid cfg_ready cfg_data| capacity register write
//
// Each item passes through a compare of the key in all 16 cells, then the
// recency update with move-to-front; the next item enters in the update cycle.
// The update of a get waits while the result register still holds an untaken item.
// Reset (aresetn low, synchronous) clears valid marks, ranks, fill count and
// sets the capacity to 16. Configuration writes are always taken.
module lru_key_value_cache_unit
    import lkvc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    lkvc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_item    (s_item),
        .m_item    (m_item),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

endmodule
